@@ hdl/cfpc_pkg.sv @@
// Package for the CRC-framed PWM command parser.
// Holds result kinds, register indexes, payload structs and the CRC function.
package cfpc_pkg;

  localparam int unsigned RegCount = 7;

  typedef enum logic [2:0] {
    REG_OP_PING       = 3'd0,
    REG_OP_WRITE_ONE  = 3'd1,
    REG_OP_READ       = 3'd2,
    REG_OP_WRITE_MANY = 3'd3,
    REG_OP_WRITE_MODE = 3'd4,
    REG_CODE_CRC_ERR  = 3'd5,
    REG_CODE_LEN_ERR  = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_DUTY = 2'd1,
    KIND_MODE = 2'd2
  } result_kind_e;

  localparam logic [7:0]  SyncByte = 8'h55;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_begin;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] tx_byte;
    logic       tx_frame_end;
    logic [3:0] duty_channel;
    logic [7:0] duty_value;
    logic [7:0] mode_value;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] data;
  } cfg_item_t;

  // Datapath commands from the controller
  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_BEGIN    = 4'd1,
    DP_BYTE     = 4'd2,
    DP_EMIT_TX  = 4'd3,
    DP_EMIT_SYN = 4'd4,
    DP_EMIT_CH  = 4'd5,
    DP_EMIT_DT  = 4'd6,
    DP_EMIT_CRH = 4'd7,
    DP_EMIT_CRL = 4'd8,
    DP_EMIT_DTY = 4'd9,
    DP_EMIT_MOD = 4'd10
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [7:0] tx_val;   // byte for DP_EMIT_TX
    logic       last;     // run_last of the emitted result
  } dp_cmd_t;

  typedef struct packed {
    logic       at_end;      // frame completes on the byte just taken
    logic       short_len;   // length byte below four
    logic       crc_ok;
    logic [7:0] func;
    logic [7:0] count;
    logic       len_ok;
    logic       ch_ok;       // current pair channel in range
    logic       more_ok;     // an in-range pair follows the current one
    logic       idle;
  } dp_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hdl/cfpc_if.sv @@
// Valid/ready channel interface carrying one payload type.
// Depends on nothing; payload width chosen by the user.
interface cfpc_if #(
  parameter int unsigned Width = 8
) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/cfpc_datapath.sv @@
// Datapath: frame capture, CRC, pair buffers, duty table, result register.
// Depends on cfpc_pkg.
module cfpc_datapath #(
  parameter int unsigned Channels = 10,
  parameter int unsigned IdxW     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfpc_pkg::in_item_t   in_i,
  input  cfpc_pkg::dp_cmd_t    cmd_i,
  input  logic [IdxW-1:0]      pair_idx_i,
  output cfpc_pkg::dp_stat_t   stat_o,
  output cfpc_pkg::out_item_t  res_o
);
  localparam int unsigned Depth = Channels;

  logic [15:0] crc_q, crc_d, tcrc_q, tcrc_d;
  logic [7:0]  pos_q, pos_d, len_q, len_d, func_q, func_d, cnt_q, cnt_d;
  logic [7:0]  mode_q, mode_d;
  logic [15:0] tail_q, tail_d;
  logic [7:0]  pch_q [Depth];
  logic [7:0]  pval_q [Depth];
  logic [7:0]  duty_q [Depth];
  logic [7:0]  cur_ch, cur_val, cur_duty;
  logic        ch_in;
  logic        more_ok;
  logic [8:0]  pidx;
  logic [7:0]  p;
  logic        in_body;
  logic [7:0]  ebyte;
  cfpc_pkg::out_item_t res_q, res_d;

  assign cur_ch  = pch_q[pair_idx_i];
  assign cur_val = pval_q[pair_idx_i];
  assign ch_in   = {1'b0, cur_ch} < 9'(Channels);
  assign cur_duty = ch_in ? duty_q[cur_ch[IdxW-1:0]] : 8'h00;

  // Look ahead for a later pair of this frame that will produce a duty update
  always_comb begin
    more_ok = 1'b0;
    for (int j = 0; j < Depth; j++) begin
      if (j > int'(pair_idx_i) && j < int'(cnt_q) && {1'b0, pch_q[j]} < 9'(Channels))
        more_ok = 1'b1;
    end
  end

  assign p       = in_i.frame_begin ? 8'h00 : pos_q;
  assign in_body = {1'b0, p} < ({1'b0, (in_i.frame_begin ? in_i.rx_byte : len_q)} - 9'd2);
  assign pidx    = ({1'b0, p} - 9'd3) >> 1;

  always_comb begin
    crc_d  = crc_q;
    pos_d  = pos_q;
    len_d  = len_q;
    func_d = func_q;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    tail_d = tail_q;
    if (cmd_i.op == cfpc_pkg::DP_BEGIN || cmd_i.op == cfpc_pkg::DP_BYTE) begin
      if (in_i.frame_begin) begin
        len_d = in_i.rx_byte; crc_d = cfpc_pkg::CrcInit;
        func_d = 8'h00; cnt_d = 8'h00; mode_d = 8'h00; tail_d = 16'h0000;
      end
      if (in_i.frame_begin && in_i.rx_byte < 8'd4) begin
        len_d = 8'h00; pos_d = 8'h00;
      end else begin
        if (in_body) begin
          crc_d = cfpc_pkg::crc_byte(in_i.frame_begin ? cfpc_pkg::CrcInit : crc_q,
                                     in_i.rx_byte);
          if (p == 8'd1) func_d = in_i.rx_byte;
          if (p == 8'd2) cnt_d = in_i.rx_byte;
        end else begin
          tail_d = {tail_q[7:0], in_i.rx_byte};
        end
        if (p == 8'd3) mode_d = in_i.rx_byte;
        pos_d = p + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= cfpc_pkg::CrcInit;
      pos_q <= '0; len_q <= '0; func_q <= '0; cnt_q <= '0;
      mode_q <= '0; tail_q <= '0;
    end else begin
      crc_q <= crc_d; pos_q <= pos_d; len_q <= len_d; func_q <= func_d;
      cnt_q <= cnt_d; mode_q <= mode_d; tail_q <= tail_d;
    end
  end

  // Pair buffers: no reset, written only from the frame body
  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == cfpc_pkg::DP_BEGIN || cmd_i.op == cfpc_pkg::DP_BYTE) &&
        !(in_i.frame_begin && in_i.rx_byte < 8'd4) && in_body && p >= 8'd3 &&
        pidx < 9'(Channels)) begin
      if (!p[0]) pval_q[pidx[IdxW-1:0]] <= in_i.rx_byte;
      else       pch_q[pidx[IdxW-1:0]]  <= in_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) duty_q[i] <= '0;
    end else if (cmd_i.op == cfpc_pkg::DP_EMIT_DTY && ch_in) begin
      duty_q[cur_ch[IdxW-1:0]] <= cur_val;
    end
  end

  always_comb begin
    ebyte = 8'h00;
    case (cmd_i.op)
      cfpc_pkg::DP_EMIT_TX:  ebyte = cmd_i.tx_val;
      cfpc_pkg::DP_EMIT_CH:  ebyte = cur_ch;
      cfpc_pkg::DP_EMIT_DT:  ebyte = cur_duty;
      default:               ebyte = 8'h00;
    endcase
  end

  always_comb begin
    tcrc_d = tcrc_q;
    res_d  = res_q;
    case (cmd_i.op)
      cfpc_pkg::DP_EMIT_SYN: begin
        res_d = '0; res_d.result_kind = cfpc_pkg::KIND_TX;
        res_d.tx_byte = cfpc_pkg::SyncByte; res_d.run_last = cmd_i.last;
        tcrc_d = cfpc_pkg::CrcInit;
      end
      cfpc_pkg::DP_EMIT_TX, cfpc_pkg::DP_EMIT_CH, cfpc_pkg::DP_EMIT_DT: begin
        res_d = '0; res_d.result_kind = cfpc_pkg::KIND_TX;
        res_d.tx_byte = ebyte; res_d.run_last = cmd_i.last;
        tcrc_d = cfpc_pkg::crc_byte(tcrc_q, ebyte);
      end
      cfpc_pkg::DP_EMIT_CRH: begin
        res_d = '0; res_d.tx_byte = tcrc_q[15:8]; res_d.run_last = cmd_i.last;
      end
      cfpc_pkg::DP_EMIT_CRL: begin
        res_d = '0; res_d.tx_byte = tcrc_q[7:0]; res_d.tx_frame_end = 1'b1;
        res_d.run_last = cmd_i.last;
      end
      cfpc_pkg::DP_EMIT_DTY: begin
        res_d = '0; res_d.result_kind = cfpc_pkg::KIND_DUTY;
        res_d.duty_channel = cur_ch[3:0]; res_d.duty_value = cur_val;
        res_d.run_last = cmd_i.last;
      end
      cfpc_pkg::DP_EMIT_MOD: begin
        res_d = '0; res_d.result_kind = cfpc_pkg::KIND_MODE;
        res_d.mode_value = mode_q; res_d.run_last = cmd_i.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tcrc_q <= tcrc_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

  assign stat_o.at_end    = (pos_q == len_q);
  assign stat_o.short_len = (len_q == 8'h00);
  assign stat_o.crc_ok    = (tail_q == crc_q);
  assign stat_o.func      = func_q;
  assign stat_o.count     = cnt_q;
  assign stat_o.len_ok    = (cnt_q <= 8'(Channels)) &&
                            ({1'b0, len_q} == 9'd5 + {cnt_q, 1'b0});
  assign stat_o.ch_ok     = ch_in;
  assign stat_o.more_ok   = more_ok;
  assign stat_o.idle      = (pos_q >= len_q);
endmodule

@@ hdl/cfpc_controller.sv @@
// Controller: accepts bytes, sequences the end-of-frame response walk.
// Depends on cfpc_pkg.
module cfpc_controller #(
  parameter int unsigned Channels = 10,
  parameter int unsigned IdxW     = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfpc_pkg::in_item_t in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  logic [7:0]         cfg_q_i [cfpc_pkg::RegCount],
  input  cfpc_pkg::dp_stat_t stat_i,
  output cfpc_pkg::dp_cmd_t  cmd_o,
  output logic [IdxW-1:0]    pair_idx_o
);
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_STAT = 6'b000100,
    ST_READ = 6'b001000,
    ST_MANY = 6'b010000,
    ST_WAIT = 6'b100000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [4:0] step_q, step_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0] scode_q, scode_d;
  logic ovalid_q, ovalid_d;
  logic [7:0] npairs;
  logic       last_pair;

  assign npairs = (stat_i.count > 8'(Channels)) ? 8'(Channels) : stat_i.count;
  assign last_pair = ({{(8-IdxW){1'b0}}, idx_q} + 8'd1 >= npairs);
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign pair_idx_o = idx_q;

  always_comb begin
    state_d = state_q; ret_d = ret_q; step_d = step_q; idx_d = idx_q;
    scode_d = scode_q; ovalid_d = ovalid_q && !out_ready_i;
    cmd_o = '{op: cfpc_pkg::DP_NOP, tx_val: 8'h00, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        // drop a byte that arrives outside a frame
        if (in_valid_i && (in_i.frame_begin || !stat_i.idle)) begin
          cmd_o.op = cfpc_pkg::DP_BYTE;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        step_d = '0; idx_d = '0; state_d = ST_IDLE;
        if (stat_i.short_len) begin
          scode_d = cfg_q_i[cfpc_pkg::REG_CODE_LEN_ERR]; state_d = ST_STAT;
        end else if (stat_i.at_end) begin
          if (!stat_i.crc_ok) begin
            scode_d = cfg_q_i[cfpc_pkg::REG_CODE_CRC_ERR]; state_d = ST_STAT;
          end else if (stat_i.func == cfg_q_i[cfpc_pkg::REG_OP_PING]) begin
            scode_d = cfg_q_i[cfpc_pkg::REG_OP_PING]; state_d = ST_STAT;
          end else if (stat_i.func == cfg_q_i[cfpc_pkg::REG_OP_WRITE_MODE]) begin
            cmd_o.op = cfpc_pkg::DP_EMIT_MOD; cmd_o.last = 1'b1;
            ovalid_d = 1'b1; ret_d = ST_IDLE; state_d = ST_WAIT;
          end else if (!stat_i.len_ok) begin
            scode_d = cfg_q_i[cfpc_pkg::REG_CODE_LEN_ERR]; state_d = ST_STAT;
          end else if (stat_i.func == cfg_q_i[cfpc_pkg::REG_OP_WRITE_ONE]) begin
            if (stat_i.count != 8'h00 && stat_i.ch_ok) begin
              cmd_o.op = cfpc_pkg::DP_EMIT_DTY; cmd_o.last = 1'b1;
              ovalid_d = 1'b1; ret_d = ST_IDLE; state_d = ST_WAIT;
            end
          end else if (stat_i.func == cfg_q_i[cfpc_pkg::REG_OP_READ]) begin
            state_d = ST_READ;
          end else if (stat_i.func == cfg_q_i[cfpc_pkg::REG_OP_WRITE_MANY]) begin
            if (stat_i.count != 8'h00) state_d = ST_MANY;
          end
        end
      end
      ST_STAT: begin
        ovalid_d = 1'b1; ret_d = ST_STAT; state_d = ST_WAIT;
        step_d = step_q + 5'd1;
        case (step_q)
          5'd0: cmd_o.op = cfpc_pkg::DP_EMIT_SYN;
          5'd1: begin cmd_o.op = cfpc_pkg::DP_EMIT_TX; cmd_o.tx_val = 8'h04; end
          5'd2: begin cmd_o.op = cfpc_pkg::DP_EMIT_TX; cmd_o.tx_val = scode_q; end
          5'd3: cmd_o.op = cfpc_pkg::DP_EMIT_CRH;
          default: begin
            cmd_o.op = cfpc_pkg::DP_EMIT_CRL; cmd_o.last = 1'b1; ret_d = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        ovalid_d = 1'b1; ret_d = ST_READ; state_d = ST_WAIT;
        step_d = step_q + 5'd1;
        case (step_q)
          5'd0: cmd_o.op = cfpc_pkg::DP_EMIT_SYN;
          5'd1: begin
            cmd_o.op = cfpc_pkg::DP_EMIT_TX;
            cmd_o.tx_val = 8'd3 + {stat_i.count[6:0], 1'b0};
          end
          5'd2: begin
            cmd_o.op = cfpc_pkg::DP_EMIT_TX; cmd_o.tx_val = cfg_q_i[cfpc_pkg::REG_OP_READ];
          end
          5'd3: begin
            cmd_o.op = cfpc_pkg::DP_EMIT_TX; cmd_o.tx_val = stat_i.count;
            if (npairs == 8'h00) step_d = 5'd6;
          end
          5'd4: cmd_o.op = cfpc_pkg::DP_EMIT_CH;
          5'd5: begin
            cmd_o.op = cfpc_pkg::DP_EMIT_DT;
            if (last_pair) step_d = 5'd6;
            else begin step_d = 5'd4; idx_d = idx_q + 1'b1; end
          end
          5'd6: cmd_o.op = cfpc_pkg::DP_EMIT_CRH;
          default: begin
            cmd_o.op = cfpc_pkg::DP_EMIT_CRL; cmd_o.last = 1'b1; ret_d = ST_IDLE;
          end
        endcase
      end
      ST_MANY: begin
        // skip out-of-range channels; mark last when no in-range pair follows
        if (stat_i.ch_ok) begin
          cmd_o.op = cfpc_pkg::DP_EMIT_DTY;
          cmd_o.last = !stat_i.more_ok;
          ovalid_d = 1'b1; state_d = ST_WAIT;
          ret_d = stat_i.more_ok ? ST_MANY : ST_IDLE;
        end else if (last_pair) begin
          state_d = ST_IDLE;
        end
        idx_d = idx_q + 1'b1;
      end
      ST_WAIT: begin
        if (!ovalid_q || out_ready_i) state_d = ret_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; ret_q <= ST_IDLE; step_q <= '0; idx_q <= '0;
      scode_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; step_q <= step_d; idx_q <= idx_d;
      scode_q <= scode_d; ovalid_q <= ovalid_d;
    end
  end
endmodule

@@ hdl/crc_framed_pwm_command_parser_core.sv @@
// Channel    | direction | payload
// in_ch      | sink      | rx_byte, frame_begin
// out_ch     | source    | result_kind .. run_last
// cfg_ch     | sink      | index (3), data (8)
// A byte is taken in the idle state and checked in the evaluation state; end
// of frame walks the pair buffer, emitting a result, then waiting for hand-off.
// Reset clears the duty table.
// A stalled output holds the controller in its wait state; no input is taken.
module crc_framed_pwm_command_parser_core #(
  parameter int unsigned CHANNELS = 10
) (
  input logic   clk_i,
  input logic   rst_ni,
  cfpc_if.sink   in_ch,
  cfpc_if.source out_ch,
  cfpc_if.sink   cfg_ch
);
  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0] cfg_q [cfpc_pkg::RegCount];
  cfpc_pkg::in_item_t  in_item;
  cfpc_pkg::cfg_item_t cfg_item;
  cfpc_pkg::out_item_t res;
  cfpc_pkg::dp_cmd_t   cmd;
  cfpc_pkg::dp_stat_t  stat;
  logic [IdxW-1:0]     pidx;

  assign in_item  = cfpc_pkg::in_item_t'(in_ch.data);
  assign cfg_item = cfpc_pkg::cfg_item_t'(cfg_ch.data);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.data = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[cfpc_pkg::REG_OP_PING]       <= 8'd0;
      cfg_q[cfpc_pkg::REG_OP_WRITE_ONE]  <= 8'd1;
      cfg_q[cfpc_pkg::REG_OP_READ]       <= 8'd2;
      cfg_q[cfpc_pkg::REG_OP_WRITE_MANY] <= 8'd3;
      cfg_q[cfpc_pkg::REG_OP_WRITE_MODE] <= 8'd4;
      cfg_q[cfpc_pkg::REG_CODE_CRC_ERR]  <= 8'd240;
      cfg_q[cfpc_pkg::REG_CODE_LEN_ERR]  <= 8'd241;
    end else if (cfg_ch.valid && {1'b0, cfg_item.index} < 4'(cfpc_pkg::RegCount)) begin
      cfg_q[cfg_item.index] <= cfg_item.data;
    end
  end

  cfpc_controller #(.Channels(CHANNELS), .IdxW(IdxW)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready), .in_i(in_item),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .cfg_q_i(cfg_q), .stat_i(stat), .cmd_o(cmd), .pair_idx_o(pidx)
  );

  cfpc_datapath #(.Channels(CHANNELS), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .in_i(in_item), .cmd_i(cmd), .pair_idx_i(pidx),
    .stat_o(stat), .res_o(res)
  );
endmodule

@@ dv/cfpc_tb_if.sv @@
// Testbench-side helpers for the CRC-framed command parser channels.
// Depends on cfpc_pkg; the channel interface itself comes from the RTL (cfpc_if).
package cfpc_tb_pkg;
  import cfpc_pkg::*;

  localparam int unsigned Channels = 10;
endpackage

@@ dv/crc_framed_pwm_command_parser_core_test.sv @@
// Self-checking test of crc_framed_pwm_command_parser_core.
// Drives frames, predicts each result from a behavioral model of the parser
// and compares them in order. Depends on cfpc_pkg, cfpc_if and cfpc_tb_pkg.
module crc_framed_pwm_command_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cfpc_pkg::*;
  import cfpc_tb_pkg::*;

  class parser_scoreboard;
    logic [7:0] regs [RegCount];
    logic [15:0] crc_acc, tail;
    logic [7:0] pos, flen, func, cnt, mode;
    logic [7:0] pch [Channels];
    logic [7:0] pval [Channels];
    logic [7:0] duty [Channels];
    out_item_t pending [$];
    int errors;
    int mismatches;

    function void clear();
      regs[REG_OP_PING] = 8'd0;
      regs[REG_OP_WRITE_ONE] = 8'd1;
      regs[REG_OP_READ] = 8'd2;
      regs[REG_OP_WRITE_MANY] = 8'd3;
      regs[REG_OP_WRITE_MODE] = 8'd4;
      regs[REG_CODE_CRC_ERR] = 8'd240;
      regs[REG_CODE_LEN_ERR] = 8'd241;
      crc_acc = 16'hFFFF;
      tail = '0;
      pos = '0;
      flen = '0;
      func = '0;
      cnt = '0;
      mode = '0;
      foreach (duty[i]) begin
        duty[i] = '0;
        pch[i] = '0;
        pval[i] = '0;
      end
      errors = 0;
      mismatches = 0;
    endfunction

    static function logic [15:0] crc8(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
    endfunction

    function void push(logic [1:0] k, logic [7:0] tx, logic fe, logic [3:0] ch,
                       logic [7:0] v, logic [7:0] m);
      out_item_t r;
      r = '{result_kind: k, tx_byte: tx, tx_frame_end: fe, duty_channel: ch,
            duty_value: v, mode_value: m, run_last: 1'b0};
      pending.push_back(r);
    endfunction

    function void send_tx(ref logic [15:0] c, input logic [7:0] b);
      c = crc8(c, b);
      push(KIND_TX, b, 0, 0, 0, 0);
    endfunction

    function void send_crc(logic [15:0] c);
      push(KIND_TX, c[15:8], 0, 0, 0, 0);
      push(KIND_TX, c[7:0], 1, 0, 0, 0);
    endfunction

    function void send_status(logic [7:0] code);
      logic [15:0] c;
      c = 16'hFFFF;
      push(KIND_TX, SyncByte, 0, 0, 0, 0);
      send_tx(c, 8'h04);
      send_tx(c, code);
      send_crc(c);
    endfunction

    function void set_duty(logic [7:0] ch, logic [7:0] v);
      if (ch < Channels) begin
        duty[ch] = v;
        push(KIND_DUTY, 0, 0, ch[3:0], v, 0);
      end
    endfunction

    function void finish_frame();
      logic [15:0] c;
      logic [7:0] ch;
      if (tail != crc_acc) send_status(regs[REG_CODE_CRC_ERR]);
      else if (func == regs[REG_OP_PING]) send_status(regs[REG_OP_PING]);
      else if (func == regs[REG_OP_WRITE_MODE]) push(KIND_MODE, 0, 0, 0, 0, mode);
      else if (cnt > Channels || int'(flen) != 5 + 2 * int'(cnt))
        send_status(regs[REG_CODE_LEN_ERR]);
      else if (func == regs[REG_OP_WRITE_ONE]) begin
        if (cnt >= 1) set_duty(pch[0], pval[0]);
      end else if (func == regs[REG_OP_READ]) begin
        c = 16'hFFFF;
        push(KIND_TX, SyncByte, 0, 0, 0, 0);
        send_tx(c, 8'(3 + 2 * cnt));
        send_tx(c, regs[REG_OP_READ]);
        send_tx(c, cnt);
        for (int i = 0; i < cnt; i++) begin
          ch = pch[i];
          send_tx(c, ch);
          send_tx(c, ch < Channels ? duty[ch] : 8'h00);
        end
        send_crc(c);
      end else if (func == regs[REG_OP_WRITE_MANY]) begin
        for (int i = 0; i < cnt; i++) set_duty(pch[i], pval[i]);
      end
    endfunction

    // Note one accepted input transaction and queue what it causes.
    function void note_input(in_item_t it);
      int before_n, p, idx;
      before_n = pending.size();
      if (it.frame_begin) begin
        flen = it.rx_byte;
        pos = 0;
        crc_acc = 16'hFFFF;
        func = 0;
        cnt = 0;
        mode = 0;
        tail = 0;
        if (it.rx_byte < 4) begin
          flen = 0;
          send_status(regs[REG_CODE_LEN_ERR]);
          pending[pending.size() - 1].run_last = 1'b1;
          return;
        end
      end else if (pos >= flen) begin
        return;
      end
      p = pos;
      if (p < int'(flen) - 2) begin
        crc_acc = crc8(crc_acc, it.rx_byte);
        if (p == 1) func = it.rx_byte;
        if (p == 2) cnt = it.rx_byte;
        if (p >= 3) begin
          idx = (p - 3) >> 1;
          if (idx < Channels) begin
            if (((p - 3) & 1) == 0) pch[idx] = it.rx_byte;
            else pval[idx] = it.rx_byte;
          end
        end
      end else begin
        tail = {tail[7:0], it.rx_byte};
      end
      if (p == 3) mode = it.rx_byte;
      pos = 8'(p + 1);
      if (pos == flen) finish_frame();
      if (pending.size() > before_n) pending[pending.size() - 1].run_last = 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("ERROR: unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (mismatches++ < 10)
          $display("ERROR: result mismatch kind %0d/%0d tx %h/%h end %b/%b ch %0d/%0d val %h/%h mode %h/%h last %b/%b (exp/got)",
                   exp_r.result_kind, got.result_kind, exp_r.tx_byte, got.tx_byte,
                   exp_r.tx_frame_end, got.tx_frame_end, exp_r.duty_channel,
                   got.duty_channel, exp_r.duty_value, got.duty_value,
                   exp_r.mode_value, got.mode_value, exp_r.run_last, got.run_last);
      end
    endfunction
  endclass

  localparam int CycleLimit = 1_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cfpc_if #(.Width($bits(in_item_t))) in_ch ();
  cfpc_if #(.Width($bits(out_item_t))) out_ch ();
  cfpc_if #(.Width($bits(cfg_item_t))) cfg_ch ();

  crc_framed_pwm_command_parser_core #(.CHANNELS(Channels)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  parser_scoreboard parser_sb;
  int cycle_count;
  bit sink_stall_on;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check every transaction, draw a stall before each ready.
  int sink_wait;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        parser_sb.check_result(out_item_t'(out_ch.data));
        sink_wait = sink_stall_on ? $urandom_range(0, 16) : 0;
        out_ch.ready <= (sink_wait == 0);
      end else if (!out_ch.ready) begin
        if (sink_wait > 0) sink_wait--;
        if (sink_wait == 0) out_ch.ready <= 1'b1;
      end
    end
  end

  bit src_gap_on;

  // Valid stays high across back-to-back bytes; drop it only for a gap.
  task automatic send_byte(logic [7:0] b, logic fb);
    in_item_t it;
    int gap;
    gap = src_gap_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.rx_byte = b;
    it.frame_begin = fb;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    parser_sb.note_input(it);
  endtask

  // Build a frame with a correct or corrupted CRC tail.
  task automatic send_frame(logic [7:0] body [$], bit bad_crc);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (body[i]) c = parser_scoreboard::crc8(c, body[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    foreach (body[i]) send_byte(body[i], i == 0);
    send_byte(c[15:8], 1'b0);
    send_byte(c[7:0], 1'b0);
  endtask

  task automatic cmd_frame(logic [7:0] fc, int n, bit bad_len, bit bad_crc);
    logic [7:0] body [$];
    int extra;
    extra = bad_len ? $urandom_range(0, 3) : 0;
    body.push_back(8'(5 + 2 * n + extra));
    body.push_back(fc);
    body.push_back(8'(n));
    for (int i = 0; i < 2 * n + extra; i++)
      body.push_back(i[0] ? 8'($urandom_range(0, 255))
                          : 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                         : $urandom_range(0, Channels - 1)));
    send_frame(body, bad_crc);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (parser_sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] v);
    cfg_item_t c;
    c.index = idx;
    c.data = v;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk_i); while (!cfg_ch.ready);
    parser_sb.regs[idx] = v;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_mix(int frames);
    logic [7:0] ops [5];
    int sel;
    for (int f = 0; f < frames; f++) begin
      ops[0] = parser_sb.regs[REG_OP_PING];
      ops[1] = parser_sb.regs[REG_OP_WRITE_ONE];
      ops[2] = parser_sb.regs[REG_OP_READ];
      ops[3] = parser_sb.regs[REG_OP_WRITE_MANY];
      ops[4] = parser_sb.regs[REG_OP_WRITE_MODE];
      sel = $urandom_range(0, 19);
      if (sel < 14)
        cmd_frame(ops[$urandom_range(0, 4)], $urandom_range(0, 4), 0, 0);
      else if (sel == 14) cmd_frame(ops[$urandom_range(0, 4)], $urandom_range(0, 3), 0, 1);
      else if (sel == 15) cmd_frame(ops[$urandom_range(1, 3)], $urandom_range(0, 3), 1, 0);
      else if (sel == 16) cmd_frame(8'($urandom_range(0, 255)), $urandom_range(0, 12), 0, 0);
      else if (sel == 17) send_byte(8'($urandom_range(0, 3)), 1'b1);
      else if (sel == 18) begin
        // Abort a frame midway: length, function code and one more byte only.
        send_byte(8'($urandom_range(6, 12)), 1'b1);
        send_byte(ops[$urandom_range(0, 4)], 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    logic [7:0] body [$];
    parser_sb = new();
    parser_sb.clear();
    cycle_count = 0;
    src_gap_on = 1'b0;
    sink_stall_on = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command, short frames, errors, full channel count.
    send_byte(8'd0, 1'b1);
    send_byte(8'd3, 1'b1);
    cmd_frame(8'd3, Channels, 0, 0);
    cmd_frame(8'd2, Channels, 0, 0);
    cmd_frame(8'd0, 0, 0, 0);
    cmd_frame(8'd1, 1, 0, 0);
    cmd_frame(8'd1, 0, 0, 0);
    body = '{8'd4, 8'd4};
    send_frame(body, 0);
    body = '{8'd6, 8'd4, 8'd1, 8'hFF};
    send_frame(body, 0);
    cmd_frame(8'd2, 11, 0, 0);
    cmd_frame(8'd3, 2, 0, 1);
    cmd_frame(8'd3, 2, 1, 0);
    cmd_frame(8'hFF, 1, 0, 0);
    send_byte(8'hFF, 1'b0);
    drain();

    src_gap_on = 1'b1;
    sink_stall_on = 1'b1;
    run_mix(2);
    drain();

    // Extremes and shared function codes.
    write_reg(REG_OP_PING, 8'hFF);
    write_reg(REG_OP_WRITE_ONE, 8'h00);
    write_reg(REG_OP_READ, 8'h80);
    write_reg(REG_OP_WRITE_MANY, 8'h80);
    write_reg(REG_OP_WRITE_MODE, 8'h7F);
    write_reg(REG_CODE_CRC_ERR, 8'h00);
    write_reg(REG_CODE_LEN_ERR, 8'hFF);
    run_mix(2);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      for (int r = 0; r < RegCount; r++)
        write_reg(reg_idx_e'(r), 8'($urandom_range(0, 255)));
      src_gap_on = ph != 1;
      sink_stall_on = ph != 2;
      run_mix(1);
      drain();
    end

    write_reg(REG_OP_PING, 8'd0);
    write_reg(REG_OP_WRITE_ONE, 8'd1);
    write_reg(REG_OP_READ, 8'd2);
    write_reg(REG_OP_WRITE_MANY, 8'd3);
    write_reg(REG_OP_WRITE_MODE, 8'd4);
    write_reg(REG_CODE_CRC_ERR, 8'd240);
    write_reg(REG_CODE_LEN_ERR, 8'd241);
    src_gap_on = 1'b1;
    sink_stall_on = 1'b1;
    run_mix(1);
    drain();

    if (parser_sb.errors == 0 && parser_sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
